FILE: rtl/bcei_pkg.sv
package bcei_pkg;

	localparam int COEF_W     = 32;
	localparam int COORD_W    = 16;
	localparam int COEF_FRAC  = COEF_W - 8;
	localparam int COORD_FRAC = COORD_W - 4;
	localparam int PFRAC      = 40;
	localparam int RECIP_BITS = 30;
	localparam int NCOEF      = 16;
	localparam int OUT_W      = 64;
	// Power and factor width: a fourth power of a Q4 coordinate needs 54 bits in Q.40.
	localparam int PW         = 56;
	// Split point of the wide factor product into two partial products.
	localparam int SPL        = 27;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_EVAL  = 2'd1;
	localparam logic [1:0] MODE_INTEG = 2'd2;

	typedef logic signed [PW-1:0] pw_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic        res;
		logic        integ;
		logic        ld;
		logic [3:0]  idx;
		coef_t       val;
	} ctl_t;

	// Rounded 2^30/(k+1) for the integral of the k-th power.
	function automatic logic [RECIP_BITS:0] recip(input logic [1:0] k);
		logic [RECIP_BITS:0] r;
		unique case (k)
			2'd0: r = (RECIP_BITS+1)'(1073741824);
			2'd1: r = (RECIP_BITS+1)'(536870912);
			2'd2: r = (RECIP_BITS+1)'(357913941);
			default: r = (RECIP_BITS+1)'(268435456);
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/bicubic_cell_eval_integrate.sv
// Bicubic cell evaluator: value at a point or integral over a rectangle.
// A result passes through stages s1 to s9 and is then held in the output register.
// Throughput: one item per cycle; the ten-stage pipeline advances as a whole and
// stops only while the output register holds an item that is not taken.
// Reset clears the coefficient table to zero and empties every pipeline stage.
module bicubic_cell_eval_integrate (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [3:0]                    coef_index,
	input  logic signed [bcei_pkg::COEF_W-1:0]  coef_value,
	input  logic signed [bcei_pkg::COORD_W-1:0] x_low,
	input  logic signed [bcei_pkg::COORD_W-1:0] x_high,
	input  logic signed [bcei_pkg::COORD_W-1:0] y_low,
	input  logic signed [bcei_pkg::COORD_W-1:0] y_high,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [bcei_pkg::OUT_W-1:0]   value,
	output logic                          saturated
);
	import bcei_pkg::*;

	// Widths of the partial products and sums.
	localparam int LL_W  = 2 * SPL + 2;
	localparam int MX_W  = PW + 1;
	localparam int HH_W  = 2 * (PW - SPL);
	localparam int XY_W  = 2 * PW;
	localparam int ML_W  = COEF_W + 33;
	localparam int MH_W  = COEF_W + 32;
	localparam int T_W   = COEF_W + 64;
	localparam int S4_W  = T_W + 2;
	localparam int TOT_W = T_W + 4;
	localparam logic signed [XY_W-1:0]  HALF_XY  = XY_W'(1) <<< (PFRAC - 1);
	localparam logic signed [TOT_W-1:0] HALF_TOT = TOT_W'(1) <<< (COEF_FRAC - 1);
	localparam pw_t ONE_Q40 = PW'(1) <<< PFRAC;
	localparam logic signed [OUT_W-1:0] MAX_OUT = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] MIN_OUT = {1'b1, {(OUT_W-1){1'b0}}};

	// Next power: round(p * c / 2^COORD_FRAC).
	function automatic pw_t pmul(input pw_t p, input coord_t c);
		logic signed [PW+COORD_W-1:0] prod;
		prod = p * c;
		prod = prod + ((PW+COORD_W)'(1) <<< (COORD_FRAC - 1));
		return prod[COORD_FRAC +: PW];
	endfunction

	// Axis factor of the integral: round((ph - pl) * recip / 2^30).
	// The difference is split into a low and a high part to keep each multiplier small.
	function automatic pw_t rdiv(input pw_t ph, input pw_t pl, input logic [1:0] k);
		logic signed [PW:0] d;
		logic signed [SPL:0] dl;
		logic signed [PW-SPL:0] dh;
		logic signed [RECIP_BITS+1:0] r;
		logic signed [SPL+RECIP_BITS+2:0] lo_prod;
		logic signed [PW-SPL+RECIP_BITS+2:0] hi_prod;
		logic signed [PW+RECIP_BITS+1:0] prod;
		d = {ph[PW-1], ph} - {pl[PW-1], pl};
		dl = $signed({1'b0, d[SPL-1:0]});
		dh = d[PW:SPL];
		r = $signed({1'b0, recip(k)});
		lo_prod = dl * r;
		hi_prod = dh * r;
		prod = hi_prod;
		prod = (prod <<< SPL) + lo_prod;
		prod = prod + ((PW+RECIP_BITS+2)'(1) <<< (RECIP_BITS - 1));
		return prod[RECIP_BITS +: PW];
	endfunction

	logic adv;
	logic out_valid_q;
	logic signed [OUT_W-1:0] value_q;
	logic sat_q;

	logic [8:0] vld_s;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9;

	coord_t crd_s1[4], crd_s2[4], crd_s3[4];
	pw_t pw_s1[4];
	pw_t pw_s2[4][2];
	pw_t pw_s3[4][3];
	pw_t pw_s4[4][4];
	pw_t fx_s5[4], fy_s5[4];
	logic signed [LL_W-1:0] pll_s6[NCOEF];
	logic signed [MX_W-1:0] plh_s6[NCOEF];
	logic signed [MX_W-1:0] phl_s6[NCOEF];
	logic signed [HH_W-1:0] phh_s6[NCOEF];
	logic signed [OUT_W-1:0] xy_s7[NCOEF];
	logic signed [ML_W-1:0] ml_s8[NCOEF];
	logic signed [MH_W-1:0] mh_s8[NCOEF];
	logic signed [S4_W-1:0] sum_s9[4];
	coef_t coef_q[NCOEF];

	pw_t fx_d[4], fy_d[4];
	logic signed [LL_W-1:0] pll_d[NCOEF];
	logic signed [MX_W-1:0] plh_d[NCOEF];
	logic signed [MX_W-1:0] phl_d[NCOEF];
	logic signed [HH_W-1:0] phh_d[NCOEF];
	logic signed [OUT_W-1:0] xy_d[NCOEF];
	logic signed [ML_W-1:0] ml_d[NCOEF];
	logic signed [MH_W-1:0] mh_d[NCOEF];
	logic signed [S4_W-1:0] sum_d[4];
	logic signed [OUT_W-1:0] value_d;
	logic sat_d;

	// The whole pipeline moves together; it holds only when the output is full and stalled.
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign saturated = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s       <= {vld_s[7:0], in_valid};
			out_valid_q <= vld_s[8] && ctl_s9.res;
		end
	end

	// Loads write the table when they reach the stage that reads it, so every
	// evaluation sees exactly the loads that were accepted before it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NCOEF; n++) begin
				coef_q[n] <= '0;
			end
		end else if (adv && vld_s[6] && ctl_s7.ld) begin
			coef_q[ctl_s7.idx] <= ctl_s7.val;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (ctl_s4.integ) begin
				fx_d[k] = rdiv(pw_s4[1][k], pw_s4[0][k], 2'(k));
				fy_d[k] = rdiv(pw_s4[3][k], pw_s4[2][k], 2'(k));
			end else if (k == 0) begin
				fx_d[k] = ONE_Q40;
				fy_d[k] = ONE_Q40;
			end else begin
				fx_d[k] = pw_s4[0][k-1];
				fy_d[k] = pw_s4[2][k-1];
			end
		end
	end

	// Each lane j*4+i multiplies the x factor of power i by the y factor of power j
	// as four partial products of the low and high halves, then rounds and
	// saturates into Q.40.
	always_comb begin
		logic signed [SPL:0] alo, blo;
		logic signed [PW-SPL-1:0] ahi, bhi;
		for (int n = 0; n < NCOEF; n++) begin
			alo = $signed({1'b0, fx_s5[n % 4][SPL-1:0]});
			ahi = fx_s5[n % 4][PW-1:SPL];
			blo = $signed({1'b0, fy_s5[n / 4][SPL-1:0]});
			bhi = fy_s5[n / 4][PW-1:SPL];
			pll_d[n] = alo * blo;
			plh_d[n] = alo * bhi;
			phl_d[n] = ahi * blo;
			phh_d[n] = ahi * bhi;
		end
	end

	always_comb begin
		logic signed [XY_W-1:0] f;
		for (int n = 0; n < NCOEF; n++) begin
			f = phh_s6[n];
			f = (f <<< SPL) + plh_s6[n] + phl_s6[n];
			f = (f <<< SPL) + pll_s6[n] + HALF_XY;
			if (f[XY_W-1:PFRAC+OUT_W-1] == '0 || f[XY_W-1:PFRAC+OUT_W-1] == '1) begin
				xy_d[n] = f[PFRAC +: OUT_W];
			end else begin
				xy_d[n] = f[XY_W-1] ? MIN_OUT : MAX_OUT;
			end
		end
	end

	always_comb begin
		for (int n = 0; n < NCOEF; n++) begin
			ml_d[n] = coef_q[n] * $signed({1'b0, xy_s7[n][31:0]});
			mh_d[n] = coef_q[n] * $signed(xy_s7[n][63:32]);
		end
	end

	always_comb begin
		logic signed [T_W-1:0] t;
		for (int g = 0; g < 4; g++) begin
			sum_d[g] = '0;
			for (int m = 0; m < 4; m++) begin
				t = mh_s8[g*4+m];
				t = (t <<< 32) + ml_s8[g*4+m];
				sum_d[g] = sum_d[g] + t;
			end
		end
	end

	always_comb begin
		logic signed [TOT_W-1:0] tot;
		tot = HALF_TOT;
		for (int g = 0; g < 4; g++) begin
			tot = tot + sum_s9[g];
		end
		if (tot[TOT_W-1:COEF_FRAC+OUT_W-1] == '0 || tot[TOT_W-1:COEF_FRAC+OUT_W-1] == '1) begin
			value_d = tot[COEF_FRAC +: OUT_W];
			sat_d   = 1'b0;
		end else begin
			value_d = tot[TOT_W-1] ? MIN_OUT : MAX_OUT;
			sat_d   = 1'b1;
		end
	end

	// Payload stages; only the valid bits above are reset.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1.res   <= (mode == MODE_EVAL) || (mode == MODE_INTEG);
			ctl_s1.integ <= (mode == MODE_INTEG);
			ctl_s1.ld    <= (mode == MODE_LOAD);
			ctl_s1.idx   <= coef_index;
			ctl_s1.val   <= coef_value;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;

			crd_s1[0] <= x_low;
			crd_s1[1] <= x_high;
			crd_s1[2] <= y_low;
			crd_s1[3] <= y_high;
			pw_s1[0] <= pw_t'(x_low) <<< (PFRAC - COORD_FRAC);
			pw_s1[1] <= pw_t'(x_high) <<< (PFRAC - COORD_FRAC);
			pw_s1[2] <= pw_t'(y_low) <<< (PFRAC - COORD_FRAC);
			pw_s1[3] <= pw_t'(y_high) <<< (PFRAC - COORD_FRAC);
			for (int c = 0; c < 4; c++) begin
				crd_s2[c]    <= crd_s1[c];
				crd_s3[c]    <= crd_s2[c];
				pw_s2[c][0]  <= pw_s1[c];
				pw_s2[c][1]  <= pmul(pw_s1[c], crd_s1[c]);
				pw_s3[c][0]  <= pw_s2[c][0];
				pw_s3[c][1]  <= pw_s2[c][1];
				pw_s3[c][2]  <= pmul(pw_s2[c][1], crd_s2[c]);
				pw_s4[c][0]  <= pw_s3[c][0];
				pw_s4[c][1]  <= pw_s3[c][1];
				pw_s4[c][2]  <= pw_s3[c][2];
				pw_s4[c][3]  <= pmul(pw_s3[c][2], crd_s3[c]);
				fx_s5[c]     <= fx_d[c];
				fy_s5[c]     <= fy_d[c];
				sum_s9[c]    <= sum_d[c];
			end
			for (int n = 0; n < NCOEF; n++) begin
				pll_s6[n] <= pll_d[n];
				plh_s6[n] <= plh_d[n];
				phl_s6[n] <= phl_d[n];
				phh_s6[n] <= phh_d[n];
				xy_s7[n]  <= xy_d[n];
				ml_s8[n]  <= ml_d[n];
				mh_s8[n]  <= mh_d[n];
			end
			value_q <= value_d;
			sat_q   <= sat_d;
		end
	end

endmodule
